@@ sv/wst_pkg.sv @@
// ----------------------------------------------------------------------------
// wst_pkg: shared definitions of the wave stencil time step
// Constants, configuration register indexes and the item kind carried down
// the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package wst_pkg;

  // Default field width (signed Q2.14 at 16 bits).
  localparam int VALUE_WIDTH_DEF = 16;

  // Gains are unsigned Q0.16.
  localparam int GAIN_WIDTH = 16;
  localparam int FRAC_BITS  = 16;

  // Half of one output LSB, added before the floor shift.
  localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

  // Configuration port.
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = GAIN_WIDTH;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LAPLACE_GAIN = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MASS_GAIN    = 1'd1;

  // Place of the incoming node within its row.
  typedef enum logic [2:0] {
    POS_START = 3'b001,
    POS_ONE   = 3'b010,
    POS_MORE  = 3'b100
  } pos_t;

  // What results one accepted node causes.
  typedef struct packed {
    logic interior;  // an interior node's update is due
    logic pass;      // the incoming node passes through unchanged
    logic last;      // the incoming node ends the row
  } kind_t;

endpackage

`default_nettype wire

@@ sv/wave_stencil_time_step.sv @@
// ----------------------------------------------------------------------------
// wave_stencil_time_step: leapfrog step of a 1-D massive wave equation
// Streams grid nodes of a row and emits their values after one time step.
// ----------------------------------------------------------------------------
// Nodes of one row enter in order, one per cycle unless stalled, carrying the
// current value and the value one step earlier (signed Q2.14 at the default
// width). Each interior node is updated to 2u - p + a*(right - 2u + left) -
// b*u, rounded to nearest (halves up) and saturated, and leaves when its right
// neighbor has arrived, with the old value as the new previous value. The
// first and last nodes of a row pass through unchanged, and tlast marks the
// last one. The datapath is an input register, a product register (two
// multipliers) and a result register. The block takes one node per cycle
// unless stalled; the last node of a row of three or more nodes causes two
// results, and as the result register sends at most one transfer per cycle,
// that node stalls the pipeline while both are sent. The gains (laplace_gain
// at index 0, mass_gain at index 1, unsigned Q0.16) must be written by the
// user only while the stream is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module wave_stencil_time_step
  import wst_pkg::*;
#(
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF,
  localparam int DATA_WIDTH  = ((2 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int EXT_WIDTH   = VALUE_WIDTH + 2,
  localparam int PA_WIDTH    = GAIN_WIDTH + 1 + EXT_WIDTH,
  localparam int PB_WIDTH    = GAIN_WIDTH + 1 + VALUE_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Configuration writes.
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  // Input nodes.
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [DATA_WIDTH-1:0]      s_axis_tdata,  // in_value, in_previous, zero pad
  input  wire logic                       s_axis_tlast,  // row_end
  // Updated nodes.
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [DATA_WIDTH-1:0]           m_axis_tdata,  // out_value, out_previous, zero pad
  output logic                            m_axis_tlast   // out_last
);

  logic [GAIN_WIDTH-1:0] laplace_gain;
  logic [GAIN_WIDTH-1:0] mass_gain;

  logic                          in_accept;
  logic signed [VALUE_WIDTH-1:0] in_value;
  logic signed [VALUE_WIDTH-1:0] in_previous;

  logic                          s1_valid;
  logic                          s1_pop;
  kind_t                         s1_kind;
  logic signed [VALUE_WIDTH-1:0] s1_left;
  logic signed [VALUE_WIDTH-1:0] s1_centre;
  logic signed [VALUE_WIDTH-1:0] s1_centre_previous;
  logic signed [VALUE_WIDTH-1:0] s1_value;
  logic signed [VALUE_WIDTH-1:0] s1_previous;

  logic                          s2_valid;
  logic                          s2_pop;
  kind_t                         s2_kind;
  logic signed [EXT_WIDTH-1:0]   s2_base;
  logic signed [PA_WIDTH-1:0]    s2_prod_laplace;
  logic signed [PB_WIDTH-1:0]    s2_prod_mass;
  logic signed [VALUE_WIDTH-1:0] s2_centre;
  logic signed [VALUE_WIDTH-1:0] s2_value;
  logic signed [VALUE_WIDTH-1:0] s2_previous;

  logic signed [VALUE_WIDTH-1:0] out_value;
  logic signed [VALUE_WIDTH-1:0] out_previous;

  // Gain registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      laplace_gain <= '0;
      mass_gain    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAPLACE_GAIN: laplace_gain <= cfg_data;
        REG_MASS_GAIN:    mass_gain    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input unpacking and handshake.
  assign in_value      = s_axis_tdata[VALUE_WIDTH-1:0];
  assign in_previous   = s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign s_axis_tready = ~s1_valid | s1_pop;
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  wst_window #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_window (
    .clk            (clk),
    .rst            (rst),
    .in_accept      (in_accept),
    .in_value       (in_value),
    .in_previous    (in_previous),
    .row_end        (s_axis_tlast),
    .pop            (s1_pop),
    .valid          (s1_valid),
    .kind           (s1_kind),
    .left           (s1_left),
    .centre         (s1_centre),
    .centre_previous(s1_centre_previous),
    .node_value     (s1_value),
    .node_previous  (s1_previous)
  );

  wst_product #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_product (
    .clk            (clk),
    .rst            (rst),
    .laplace_gain   (laplace_gain),
    .mass_gain      (mass_gain),
    .in_valid       (s1_valid),
    .in_kind        (s1_kind),
    .left           (s1_left),
    .centre         (s1_centre),
    .centre_previous(s1_centre_previous),
    .node_value     (s1_value),
    .node_previous  (s1_previous),
    .in_pop         (s1_pop),
    .pop            (s2_pop),
    .valid          (s2_valid),
    .kind           (s2_kind),
    .base           (s2_base),
    .prod_laplace   (s2_prod_laplace),
    .prod_mass      (s2_prod_mass),
    .centre_out     (s2_centre),
    .pass_value     (s2_value),
    .pass_previous  (s2_previous)
  );

  wst_combine #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_combine (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s2_valid),
    .kind         (s2_kind),
    .base         (s2_base),
    .prod_laplace (s2_prod_laplace),
    .prod_mass    (s2_prod_mass),
    .centre       (s2_centre),
    .pass_value   (s2_value),
    .pass_previous(s2_previous),
    .in_pop       (s2_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_value    (out_value),
    .out_previous (out_previous),
    .out_last     (m_axis_tlast)
  );

  // Output packing.
  assign m_axis_tdata = DATA_WIDTH'({out_previous, out_value});

  // Every item left in the pipeline causes at least one result.
  assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_kind.interior || s2_kind.pass))
    else $error("pipeline item without any result");

  // An interior update and a pass-through together only occur at a row end.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_kind.interior && s1_kind.pass) |-> s1_kind.last)
    else $error("double result away from the row end");

  // After reset no result is offered.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

endmodule

`default_nettype wire

@@ sv/wst_window.sv @@
// ----------------------------------------------------------------------------
// wst_window: three-node window and input register
// Tracks the position in the row, keeps the two most recent nodes and
// registers each node that causes results together with its window.
// ----------------------------------------------------------------------------
`default_nettype none

module wst_window
  import wst_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_accept,
  input  wire logic signed [VALUE_WIDTH-1:0] in_value,
  input  wire logic signed [VALUE_WIDTH-1:0] in_previous,
  input  wire logic                          row_end,
  input  wire logic                          pop,
  output logic                               valid,
  output kind_t                              kind,
  output logic signed [VALUE_WIDTH-1:0]      left,
  output logic signed [VALUE_WIDTH-1:0]      centre,
  output logic signed [VALUE_WIDTH-1:0]      centre_previous,
  output logic signed [VALUE_WIDTH-1:0]      node_value,
  output logic signed [VALUE_WIDTH-1:0]      node_previous
);

  pos_t                         position;
  pos_t                         position_next;
  logic signed [VALUE_WIDTH-1:0] value_two_back;
  logic signed [VALUE_WIDTH-1:0] value_one_back;
  logic signed [VALUE_WIDTH-1:0] previous_one_back;
  kind_t                        kind_next;
  logic                         shift_window;

  // Decide the results of the incoming node and the next row position.
  always_comb begin
    kind_next     = '0;
    position_next = position;
    shift_window  = 1'b0;
    kind_next.last = row_end;
    case (position)
      POS_START: begin
        kind_next.pass = 1'b1;
        if (!row_end) begin
          position_next = POS_ONE;
          shift_window  = 1'b1;
        end
      end
      POS_ONE, POS_MORE: begin
        kind_next.interior = (position == POS_MORE);
        kind_next.pass     = row_end;
        if (row_end) begin
          position_next = POS_START;
        end else begin
          position_next = POS_MORE;
          shift_window  = 1'b1;
        end
      end
      default: begin
        // Unknown codes behave as two or more nodes seen.
        kind_next.interior = 1'b1;
        kind_next.pass     = row_end;
        if (row_end) begin
          position_next = POS_START;
        end else begin
          position_next = POS_MORE;
          shift_window  = 1'b1;
        end
      end
    endcase
  end

  // Window state, updated on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      position          <= POS_START;
      value_two_back    <= '0;
      value_one_back    <= '0;
      previous_one_back <= '0;
    end else if (in_accept) begin
      position <= position_next;
      if (shift_window) begin
        value_two_back    <= value_one_back;
        value_one_back    <= in_value;
        previous_one_back <= in_previous;
      end
    end
  end

  // Input register valid flag. A node that causes no result is dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_accept) begin
      valid <= kind_next.interior | kind_next.pass;
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind            <= kind_next;
      left            <= value_two_back;
      centre          <= value_one_back;
      centre_previous <= previous_one_back;
      node_value      <= in_value;
      node_previous   <= in_previous;
    end
  end

endmodule

`default_nettype wire

@@ sv/wst_product.sv @@
// ----------------------------------------------------------------------------
// wst_product: stencil products
// Forms the Laplacian and the two gain products of the window and
// registers them with the pass-through fields.
// ----------------------------------------------------------------------------
`default_nettype none

module wst_product
  import wst_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int EXT_WIDTH  = VALUE_WIDTH + 2,
  localparam int PA_WIDTH   = GAIN_WIDTH + 1 + EXT_WIDTH,
  localparam int PB_WIDTH   = GAIN_WIDTH + 1 + VALUE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [GAIN_WIDTH-1:0]         laplace_gain,
  input  wire logic [GAIN_WIDTH-1:0]         mass_gain,
  input  wire logic                          in_valid,
  input  wire kind_t                         in_kind,
  input  wire logic signed [VALUE_WIDTH-1:0] left,
  input  wire logic signed [VALUE_WIDTH-1:0] centre,
  input  wire logic signed [VALUE_WIDTH-1:0] centre_previous,
  input  wire logic signed [VALUE_WIDTH-1:0] node_value,
  input  wire logic signed [VALUE_WIDTH-1:0] node_previous,
  output logic                               in_pop,
  input  wire logic                          pop,
  output logic                               valid,
  output kind_t                              kind,
  output logic signed [EXT_WIDTH-1:0]        base,
  output logic signed [PA_WIDTH-1:0]         prod_laplace,
  output logic signed [PB_WIDTH-1:0]         prod_mass,
  output logic signed [VALUE_WIDTH-1:0]      centre_out,
  output logic signed [VALUE_WIDTH-1:0]      pass_value,
  output logic signed [VALUE_WIDTH-1:0]      pass_previous
);

  logic signed [EXT_WIDTH-1:0]  laplacian;
  logic signed [EXT_WIDTH-1:0]  base_next;
  logic signed [GAIN_WIDTH:0]   laplace_s;
  logic signed [GAIN_WIDTH:0]   mass_s;
  logic signed [PA_WIDTH-1:0]   prod_laplace_next;
  logic signed [PB_WIDTH-1:0]   prod_mass_next;

  // The stage takes a new item when empty or when its item moves on.
  assign in_pop = in_valid & (~valid | pop);

  // Laplacian, leapfrog base and the two gain products.
  always_comb begin
    laplace_s = $signed({1'b0, laplace_gain});
    mass_s    = $signed({1'b0, mass_gain});
    laplacian = EXT_WIDTH'(node_value) - (EXT_WIDTH'(centre) <<< 1) + EXT_WIDTH'(left);
    base_next = (EXT_WIDTH'(centre) <<< 1) - EXT_WIDTH'(centre_previous);
    prod_laplace_next = laplace_s * laplacian;
    prod_mass_next    = mass_s * centre;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_pop) begin
      valid <= 1'b1;
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      kind          <= in_kind;
      base          <= base_next;
      prod_laplace  <= prod_laplace_next;
      prod_mass     <= prod_mass_next;
      centre_out    <= centre;
      pass_value    <= node_value;
      pass_previous <= node_previous;
    end
  end

endmodule

`default_nettype wire

@@ sv/wst_combine.sv @@
// ----------------------------------------------------------------------------
// wst_combine: sum, rounding, saturation and result register
// Adds the products, rounds to nearest, saturates and loads the result
// register; an item with two results is sent out over two transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module wst_combine
  import wst_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int EXT_WIDTH  = VALUE_WIDTH + 2,
  localparam int PA_WIDTH   = GAIN_WIDTH + 1 + EXT_WIDTH,
  localparam int PB_WIDTH   = GAIN_WIDTH + 1 + VALUE_WIDTH,
  localparam int SUM_WIDTH  = PA_WIDTH + 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire kind_t                         kind,
  input  wire logic signed [EXT_WIDTH-1:0]   base,
  input  wire logic signed [PA_WIDTH-1:0]    prod_laplace,
  input  wire logic signed [PB_WIDTH-1:0]    prod_mass,
  input  wire logic signed [VALUE_WIDTH-1:0] centre,
  input  wire logic signed [VALUE_WIDTH-1:0] pass_value,
  input  wire logic signed [VALUE_WIDTH-1:0] pass_previous,
  output logic                               in_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0]      out_value,
  output logic signed [VALUE_WIDTH-1:0]      out_previous,
  output logic                               out_last
);

  logic                          load;
  logic                          send_interior;
  logic                          interior_done;
  logic signed [SUM_WIDTH-1:0]   total;
  logic signed [SUM_WIDTH-1:0]   shifted;
  logic signed [VALUE_WIDTH-1:0] update;

  // The result register can take a new result when empty or being drained.
  assign load = ~out_valid | out_ready;

  // The interior update goes first; a pass-through of the same item follows.
  assign send_interior = kind.interior & ~interior_done;
  assign in_pop = in_valid & load & ~(send_interior & kind.pass);

  // Exact total, round half up, floor shift and saturate.
  always_comb begin
    total = (SUM_WIDTH'(base) <<< FRAC_BITS) + SUM_WIDTH'(prod_laplace)
          - SUM_WIDTH'(prod_mass) + SUM_WIDTH'(ROUND_BIAS);
    shifted = total >>> FRAC_BITS;
    if (!shifted[SUM_WIDTH-1] && (|shifted[SUM_WIDTH-2:VALUE_WIDTH-1])) begin
      update = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end else if (shifted[SUM_WIDTH-1] && !(&shifted[SUM_WIDTH-2:VALUE_WIDTH-1])) begin
      update = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      update = shifted[VALUE_WIDTH-1:0];
    end
  end

  // Result valid flag and the marker for a half-sent item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      interior_done <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
      if (in_valid) begin
        interior_done <= send_interior & kind.pass;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      if (send_interior) begin
        out_value    <= update;
        out_previous <= centre;
        out_last     <= 1'b0;
      end else begin
        out_value    <= pass_value;
        out_previous <= pass_previous;
        out_last     <= kind.last;
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/wst_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wst_checker: scoreboard of the wave stencil time step
// Watches the configuration port and both streams, computes the updated
// nodes that every accepted input node causes and compares each output
// transfer field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------

module wst_checker
  import wst_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]                 cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]                  cfg_data,
  input  logic                                       s_axis_tvalid,
  input  logic                                       s_axis_tready,
  input  logic [((2 * VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,  // in_value, in_previous
  input  logic                                       s_axis_tlast,  // row_end
  input  logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  input  logic [((2 * VALUE_WIDTH + 7) / 8) * 8-1:0] m_axis_tdata,  // out_value, out_previous
  input  logic                                       m_axis_tlast,  // out_last
  output int                                         errors,
  output int                                         outstanding
);

  typedef logic signed [VALUE_WIDTH-1:0] node_value_t;

  // One updated node as it should leave the block.
  typedef struct packed {
    node_value_t value;
    node_value_t previous;
    logic        last;
  } updated_node_t;

  updated_node_t updated_nodes_q[$];

  // Own copy of the gains and of the three-node window.
  logic [GAIN_WIDTH-1:0] laplace_gain_q;
  logic [GAIN_WIDTH-1:0] mass_gain_q;
  node_value_t           left_value;
  node_value_t           centre_value;
  node_value_t           centre_previous;
  pos_t                  row_pos;

  // New value of an interior node: exact sum, round half up, saturate.
  function automatic node_value_t leapfrog_value(node_value_t left, node_value_t centre,
                                                 node_value_t right, node_value_t prev);
    longint lap;
    longint total;
    longint shifted;
    longint vmax;
    longint vmin;
    lap   = longint'(right) - 2 * longint'(centre) + longint'(left);
    total = (2 * longint'(centre) - longint'(prev)) * (longint'(1) << FRAC_BITS)
          + longint'(laplace_gain_q) * lap
          - longint'(mass_gain_q) * longint'(centre);
    shifted = (total + longint'(ROUND_BIAS)) >>> FRAC_BITS;
    vmax = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
    vmin = -vmax - 1;
    if (shifted > vmax) shifted = vmax;
    if (shifted < vmin) shifted = vmin;
    return shifted[VALUE_WIDTH-1:0];
  endfunction

  task automatic push_node(node_value_t value, node_value_t previous, logic last);
    updated_node_t node;
    node.value    = value;
    node.previous = previous;
    node.last     = last;
    updated_nodes_q.push_back(node);
  endtask

  // Advance the window by one input node and queue what it releases.
  task automatic take_input_node(node_value_t value, node_value_t previous, logic row_end);
    if (row_pos == POS_START) begin
      push_node(value, previous, row_end);
      if (!row_end) begin
        centre_value    = value;
        centre_previous = previous;
        row_pos         = POS_ONE;
      end
    end else begin
      // The centre node is interior once a left neighbor exists.
      if (row_pos == POS_MORE) begin
        push_node(leapfrog_value(left_value, centre_value, value, centre_previous),
                  centre_value, 1'b0);
      end
      if (row_end) begin
        push_node(value, previous, 1'b1);
        row_pos = POS_START;
      end else begin
        left_value      = centre_value;
        centre_value    = value;
        centre_previous = previous;
        row_pos         = POS_MORE;
      end
    end
  endtask

  always @(posedge clk) begin
    updated_node_t expected;
    node_value_t   got_value;
    node_value_t   got_previous;
    if (rst) begin
      laplace_gain_q  = '0;
      mass_gain_q     = '0;
      left_value      = '0;
      centre_value    = '0;
      centre_previous = '0;
      row_pos         = POS_START;
      errors          = 0;
      updated_nodes_q.delete();
    end else begin
      // Register writes take effect for the nodes that follow.
      if (cfg_we) begin
        case (cfg_index)
          REG_LAPLACE_GAIN: laplace_gain_q = cfg_data;
          REG_MASS_GAIN:    mass_gain_q    = cfg_data;
          default: ;
        endcase
      end

      // Compare an output transfer with the oldest expected node.
      if (m_axis_tvalid && m_axis_tready) begin
        got_value    = m_axis_tdata[VALUE_WIDTH-1:0];
        got_previous = m_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
        if (updated_nodes_q.size() == 0) begin
          $error("output transfer with no node expected: out_value %0d, out_previous %0d",
                 got_value, got_previous);
          errors++;
        end else begin
          expected = updated_nodes_q.pop_front();
          if (got_value !== expected.value) begin
            $error("out_value mismatch: expected %0d, actual %0d", expected.value, got_value);
            errors++;
          end
          if (got_previous !== expected.previous) begin
            $error("out_previous mismatch: expected %0d, actual %0d",
                   expected.previous, got_previous);
            errors++;
          end
          if (m_axis_tlast !== expected.last) begin
            $error("out_last mismatch: expected %0b, actual %0b", expected.last, m_axis_tlast);
            errors++;
          end
        end
      end

      // An input transfer releases zero, one or two updated nodes.
      if (s_axis_tvalid && s_axis_tready) begin
        take_input_node(s_axis_tdata[VALUE_WIDTH-1:0],
                        s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH], s_axis_tlast);
      end
    end
    outstanding <= updated_nodes_q.size();
  end

endmodule

@@ tb/tb_wave_stencil_time_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wave_stencil_time_step: testbench of the wave stencil time step
// Streams rows of grid nodes through the block under several gain settings,
// with random gaps on both streams, and lets the checker judge each output.
// ----------------------------------------------------------------------------

module tb_wave_stencil_time_step;
  import wst_pkg::*;

  localparam int VALUE_WIDTH   = VALUE_WIDTH_DEF;
  localparam int DATA_WIDTH    = ((2 * VALUE_WIDTH + 7) / 8) * 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_NODES   = 95;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_LAPLACE_GAIN;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [DATA_WIDTH-1:0]      s_axis_tdata = '0;  // in_value, in_previous, zero pad
  logic                       s_axis_tlast = 1'b0;  // row_end
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [DATA_WIDTH-1:0]      m_axis_tdata;  // out_value, out_previous, zero pad
  logic                       m_axis_tlast;  // out_last

  int fail_count;
  int pending_nodes;
  int cycle_count = 0;
  bit src_burst = 1'b0;
  bit sink_burst = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wave_stencil_time_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  wst_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .errors       (fail_count),
    .outstanding  (pending_nodes)
  );

  // Field values lean toward the extremes, where saturation happens.
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0, 1:    return {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
      2, 3:    return {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
      4:       return '0;
      5:       return VALUE_WIDTH'($urandom_range(0, 511)) - VALUE_WIDTH'(256);
      default: return VALUE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_WIDTH-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return GAIN_WIDTH'($urandom_range(0, 4095));
      3:       return GAIN_WIDTH'($urandom_range(8192, 24576));
      default: return GAIN_WIDTH'($urandom);
    endcase
  endfunction

  // Mostly short rows, now and then a long one.
  function automatic int pick_row_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return $urandom_range(1, 2);
    if (r < 15) return $urandom_range(3, 10);
    if (r < 19) return $urandom_range(11, 30);
    return $urandom_range(60, 100);
  endfunction

  // Offer one node after a random gap and hold it until the transfer.
  task automatic send_node(logic [VALUE_WIDTH-1:0] value, logic [VALUE_WIDTH-1:0] previous,
                           logic row_end);
    int                    gap;
    logic [DATA_WIDTH-1:0] word;
    gap = src_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = '0;
    word[VALUE_WIDTH-1:0] = value;
    word[2*VALUE_WIDTH-1:VALUE_WIDTH] = previous;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tlast  <= row_end;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_row(int length);
    for (int i = 0; i < length; i++) begin
      send_node(pick_value(), pick_value(), i == length - 1);
    end
  endtask

  // Stop offering nodes and wait until every expected node has left.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_nodes != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_gains(logic [GAIN_WIDTH-1:0] laplace, logic [GAIN_WIDTH-1:0] mass);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LAPLACE_GAIN;
    cfg_data  <= laplace;
    @(posedge clk);
    cfg_index <= REG_MASS_GAIN;
    cfg_data  <= mass;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Run guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** wave_stencil_time_step: FAILED **");
      $finish;
    end
  end

  // Output side: random stalls, with stretches of steady acceptance.
  initial begin
    int gap;
    int taken;
    taken = 0;
    do @(posedge clk); while (rst);
    forever begin
      gap = sink_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      taken++;
      if (taken % 40 == 0) sink_burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int                    sent;
    int                    length;
    logic [GAIN_WIDTH-1:0] laplace;
    logic [GAIN_WIDTH-1:0] mass;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero gains: rows of one, two, three and four nodes, interior values
    // saturating at both ends of the range.
    write_gains('0, '0);
    send_node(16'sh7FFF, 16'sh8000, 1'b1);
    send_node(16'sh8000, 16'sh7FFF, 1'b0);
    send_node(16'sh0000, 16'sh0000, 1'b1);
    send_node(16'sh0001, 16'sh0002, 1'b0);
    send_node(16'sh7FFF, 16'sh8000, 1'b0);
    send_node(16'shFFFF, 16'sh0000, 1'b1);
    send_node(16'sh0000, 16'sh0000, 1'b0);
    send_node(16'sh8000, 16'sh7FFF, 1'b0);
    send_node(16'sh7FFF, 16'sh8000, 1'b0);
    send_node(16'sh8000, 16'sh7FFF, 1'b1);
    wait_drained();

    // Full gains: alternating extremes give the widest Laplacian.
    write_gains('1, '1);
    send_node(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_node(16'sh8000, 16'sh8000, 1'b0);
    send_node(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_node(16'sh8000, 16'sh8000, 1'b0);
    send_node(16'sh0000, 16'sh0000, 1'b1);
    send_node(16'sh0064, 16'sh0032, 1'b0);
    send_node(16'sh00C8, 16'shFED4, 1'b0);
    send_node(16'sh012C, 16'sh0007, 1'b1);
    send_node(16'sh8000, 16'sh0000, 1'b0);
    send_node(16'sh0000, 16'sh7FFF, 1'b0);
    send_node(16'sh7FFF, 16'sh0000, 1'b1);
    wait_drained();

    // Random rows under a new pair of gains in every phase.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          laplace = '1;
          mass    = '0;
        end
        1: begin
          laplace = '0;
          mass    = '1;
        end
        default: begin
          laplace = pick_gain();
          mass    = pick_gain();
        end
      endcase
      write_gains(laplace, mass);
      sent = 0;
      while (sent < PHASE_NODES) begin
        length    = pick_row_length();
        src_burst = ($urandom_range(0, 4) == 0);
        send_row(length);
        sent += length;
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** wave_stencil_time_step: PASSED **");
    end else begin
      $display("** wave_stencil_time_step: FAILED **");
    end
    $finish;
  end

endmodule
